@@ rtl/core/swv_pkg.sv @@
// Shared types, constants and width helpers for the sliding window variance unit.
package swv_pkg;

  localparam int MAX_WINDOW_DEF  = 128;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_W           = 8;
  localparam int OUT_W           = 38;
  localparam int FRAC_BITS       = 8;
  localparam logic [CFG_W-1:0] RESET_WINDOW = 8'd100;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_wr;    // write zero to the ring at the sweep address
    logic smp_wr;    // store the accepted sample and advance the write slot
    logic rd_en;     // read the ring at the scan address
    logic acc_clr;   // zero the sum accumulators
    logic fin_abs;   // take the magnitude of the sum
    logic fin_mul;   // form W*Q, S*S and W*W
    logic div_load;  // load the divider with the numerator
    logic div_step;  // one restoring division step
    logic out_load;  // move the quotient into the output register
  } swv_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_full;  // output word held and not taken this cycle
  } swv_sts_t;

  function automatic int max_int(int a, int b);
    return (a > b) ? a : b;
  endfunction

  // Dividend width: numerator W*Q plus the fraction bits
  function automatic int dvd_width(int mw, int sb);
    return 2 * sb + $clog2(mw) + $clog2(mw + 1) + FRAC_BITS;
  endfunction

endpackage

@@ rtl/core/swv_ctrl.sv @@
// Controller state machine: clearing sweep, window scan, finish steps and divide sequencing.
module swv_ctrl
  import swv_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_WINDOW),
  localparam int WIN_W = $clog2(MAX_WINDOW + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [WIN_W-1:0] win,
  input  swv_sts_t         sts,
  output swv_cmd_t         cmd,
  output logic [IDX_W-1:0] addr
);

  localparam int DVD_W   = dvd_width(MAX_WINDOW, SAMPLE_BITS);
  localparam int CNT_MAX = max_int(MAX_WINDOW + 1, DVD_W);
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_ABS   = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_LOAD  = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] win_ext;
  logic             accept;

  assign win_ext   = CNT_W'(win);
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign addr      = cnt_r[IDX_W-1:0];

  // Next state, counter and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (cnt_r == CNT_W'(MAX_WINDOW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.smp_wr  = 1'b1;
          cmd.acc_clr = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // reads issue while the count is below W, then the read and square stages drain
        cmd.rd_en = (cnt_r < win_ext);
        if (cnt_r == win_ext + CNT_W'(1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_ABS;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ABS: begin
        cmd.fin_abs = 1'b1;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.fin_mul = 1'b1;
        state_nxt   = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        // hold until the output register frees up
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/swv_datapath.sv @@
// Datapath: sample ring, sum accumulators, finish multipliers, restoring divider, output register.
module swv_datapath
  import swv_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_WINDOW),
  localparam int WIN_W = $clog2(MAX_WINDOW + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wen,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  swv_cmd_t               cmd,
  input  logic [IDX_W-1:0]       addr,
  output logic [WIN_W-1:0]       win,
  output swv_sts_t               sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_W-1:0]       variance_q8
);

  localparam int B     = SAMPLE_BITS;
  localparam int SUM_W = B + IDX_W + 1;
  localparam int SS_W  = 2 * SUM_W;
  localparam int Q_W   = 2 * B + IDX_W;
  localparam int N_W   = Q_W + WIN_W;
  localparam int D_W   = 2 * WIN_W;
  localparam int DVD_W = dvd_width(MAX_WINDOW, SAMPLE_BITS);
  localparam int CMP_W = max_int(CFG_W, WIN_W);

  // Window length register and its clamp to 1..MAX_WINDOW
  logic [CFG_W-1:0] cfg_r;
  logic [CMP_W-1:0] cfg_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= RESET_WINDOW;
    end else if (cfg_wen) begin
      cfg_r <= cfg_wdata;
    end
  end

  assign cfg_ext = CMP_W'(cfg_r);

  always_comb begin
    if (cfg_r == '0) begin
      win = WIN_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_WINDOW)) begin
      win = WIN_W'(MAX_WINDOW);
    end else begin
      win = WIN_W'(cfg_ext);
    end
  end

  // Write slot: restart at zero if the window shrank, wrap at W
  logic [IDX_W-1:0] slot_r, slot_nxt, slot_use;
  logic [WIN_W-1:0] slot_inc;

  assign slot_use = (WIN_W'(slot_r) >= win) ? '0 : slot_r;
  assign slot_inc = WIN_W'(slot_use) + WIN_W'(1);
  assign slot_nxt = (slot_inc >= win) ? '0 : slot_inc[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (cmd.smp_wr) begin
      slot_r <= slot_nxt;
    end
  end

  // Sample ring: one write port, one registered read port
  logic [B-1:0] ring_r [MAX_WINDOW];
  logic [B-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      ring_r[addr] <= '0;
    end else if (cmd.smp_wr) begin
      ring_r[slot_use] <= sample;
    end
    if (cmd.rd_en) begin
      rd_data_r <= ring_r[addr];
    end
  end

  // Square stage, then accumulate
  logic                   rd_vld_r, sq_vld_r;
  logic [B-1:0]           val_r;
  logic [2*B-1:0]         sq_r;
  logic signed [2*B-1:0]  rd_ext;
  logic signed [2*B-1:0]  sq_full;
  logic [SUM_W-1:0]       s_r;
  logic [Q_W-1:0]         q_r;

  assign rd_ext  = $signed({{B{rd_data_r[B-1]}}, rd_data_r});
  assign sq_full = rd_ext * rd_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      sq_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      sq_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      val_r <= rd_data_r;
      sq_r  <= $unsigned(sq_full);
    end
    if (cmd.acc_clr) begin
      s_r <= '0;
      q_r <= '0;
    end else if (sq_vld_r) begin
      s_r <= s_r + {{(SUM_W - B){val_r[B-1]}}, val_r};
      q_r <= q_r + {{(Q_W - 2 * B){1'b0}}, sq_r};
    end
  end

  // Finish: |S|, then W*Q, S*S and W*W in parallel
  logic [SUM_W-1:0]   s_abs_r;
  logic [SS_W-1:0]    ss_full;
  logic [N_W-1:0]     wq_r, ss_r;
  logic [D_W-1:0]     den_r;

  assign ss_full = SS_W'(s_abs_r) * SS_W'(s_abs_r);

  always_ff @(posedge clk) begin
    if (cmd.fin_abs) begin
      s_abs_r <= s_r[SUM_W-1] ? (~s_r + 1'b1) : s_r;
    end
    if (cmd.fin_mul) begin
      wq_r  <= N_W'(win) * N_W'(q_r);
      ss_r  <= ss_full[N_W-1:0];
      den_r <= D_W'(win) * D_W'(win);
    end
  end

  // Restoring divider: quotient bits shift in behind the dividend
  logic [DVD_W-1:0] dvd_r;
  logic [D_W-1:0]   rem_r;
  logic [D_W:0]     trial;
  logic             q_bit;
  logic [D_W-1:0]   trial_sub;

  assign trial     = {rem_r, dvd_r[DVD_W-1]};
  assign q_bit     = (trial >= {1'b0, den_r});
  assign trial_sub = trial[D_W-1:0] - den_r;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd_r <= {wq_r - ss_r, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DVD_W-2:0], q_bit};
      rem_r <= q_bit ? trial_sub : trial[D_W-1:0];
    end
  end

  // Output register
  logic             out_vld_r;
  logic [OUT_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= OUT_W'(dvd_r);
    end
  end

  assign out_tvalid   = out_vld_r;
  assign variance_q8  = out_data_r;
  assign sts.out_full = out_vld_r && !out_tready;

endmodule

@@ rtl/core/sliding_window_variance_unit.sv @@
// Flow: an accepted sample word is stored, then the window scan reads one ring slot per cycle
// and the read and square stages drain, then the finish states ABS, MUL and LOAD run, then
// one restoring divide step per quotient bit (55 bits at defaults) and the output load.
// A new word is taken only once the last result is in the output register; that register lets it in early.
// Reset: rst_n synchronous, active low; afterwards a sweep zeros every ring slot
// with in_tready low, and the window length returns to 100.
module sliding_window_variance_unit
  import swv_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wen,
  input  logic [CFG_W-1:0]       cfg_wdata,    // window_length
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,     // sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata     // variance_q8
);

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int WIN_W = $clog2(MAX_WINDOW + 1);

  swv_cmd_t         cmd;
  swv_sts_t         sts;
  logic [IDX_W-1:0] addr;
  logic [WIN_W-1:0] win;
  logic [OUT_W-1:0] variance_q8;

  swv_ctrl #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .win       (win),
    .sts       (sts),
    .cmd       (cmd),
    .addr      (addr)
  );

  swv_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .sample      (in_tdata[SAMPLE_BITS-1:0]),
    .cmd         (cmd),
    .addr        (addr),
    .win         (win),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .variance_q8 (variance_q8)
  );

  // Zero-pad the result to whole bytes
  assign out_tdata = OUT_TDATA_W'(variance_q8);

endmodule

@@ rtl/core/swv_checker.sv @@
// Port-level checks for the sliding window variance unit, bound to the top level.
module swv_checker
  import swv_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // Pad bits above the result stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:38] == 2'b00)
    else $error("output pad bits set");

  // One word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is in progress");

  // Reset empties the output and starts the clearing sweep
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("reset did not quiesce the ports");

endmodule

bind sliding_window_variance_unit swv_checker u_swv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/tb_sliding_window_variance_unit.sv @@
// Testbench for the sliding window variance unit: directed table plus random windows.
`timescale 1ns / 1ps

module tb_sliding_window_variance_unit;
  import swv_pkg::*;

  localparam int IN_W      = 16;
  localparam int OUT_DW    = ((OUT_W + 7) / 8) * 8;
  localparam int RING_SIZE = MAX_WINDOW_DEF;
  localparam int DIR_ROWS  = 24;
  localparam int RAND_ITEMS = 550;

  typedef enum logic [0:0] {
    ROW_SAMPLE,
    ROW_WINDOW
  } row_kind_t;

  // One directed step: a sample word or a window length write
  typedef struct packed {
    row_kind_t        kind;
    logic [IN_W-1:0]  value;
    logic             typed;
    logic [OUT_W-1:0] result;
  } stim_row_t;

  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_SAMPLE, 16'h0000, 1'b1, 38'd0},            // reset window of 100, all zero
    '{ROW_WINDOW, 16'd1,    1'b0, 38'd0},
    '{ROW_SAMPLE, 16'h7fff, 1'b1, 38'd0},            // single slot never varies
    '{ROW_SAMPLE, 16'h8000, 1'b1, 38'd0},
    '{ROW_WINDOW, 16'd0,    1'b0, 38'd0},            // zero length acts as one
    '{ROW_SAMPLE, 16'h3039, 1'b1, 38'd0},
    '{ROW_WINDOW, 16'd2,    1'b0, 38'd0},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 38'd68719476736},  // -32768 beside a cleared slot
    '{ROW_SAMPLE, 16'h7fff, 1'b0, 38'd0},            // widest spread
    '{ROW_SAMPLE, 16'h8000, 1'b0, 38'd0},            // ring wraps to slot 0
    '{ROW_WINDOW, 16'd255,  1'b0, 38'd0},            // saturates to the ring size
    '{ROW_SAMPLE, 16'h7fff, 1'b0, 38'd0},
    '{ROW_SAMPLE, 16'h0001, 1'b0, 38'd0},
    '{ROW_SAMPLE, 16'hffff, 1'b0, 38'd0},
    '{ROW_SAMPLE, 16'h1234, 1'b0, 38'd0},
    '{ROW_WINDOW, 16'd128,  1'b0, 38'd0},
    '{ROW_SAMPLE, 16'h5555, 1'b0, 38'd0},
    '{ROW_WINDOW, 16'd3,    1'b0, 38'd0},            // write slot now past the window
    '{ROW_SAMPLE, 16'hfffb, 1'b0, 38'd0},
    '{ROW_SAMPLE, 16'hfffb, 1'b0, 38'd0},
    '{ROW_SAMPLE, 16'hfffb, 1'b1, 38'd0},            // constant window
    '{ROW_SAMPLE, 16'hfffb, 1'b1, 38'd0},
    '{ROW_WINDOW, 16'd128,  1'b0, 38'd0},            // grow: old slots count again
    '{ROW_SAMPLE, 16'haaaa, 1'b0, 38'd0}
  };

  logic               clk;
  logic               rst_n;
  logic               cfg_wen;
  logic [CFG_W-1:0]   cfg_wdata;
  logic               in_tvalid;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata;    // sample
  logic               out_tvalid;
  logic               out_tready;
  logic [OUT_DW-1:0]  out_tdata;   // variance_q8

  // Shadow copy of the window state
  logic signed [IN_W-1:0] shadow_ring [RING_SIZE];
  int                     shadow_slot;
  logic [CFG_W-1:0]       shadow_length;

  logic [OUT_W-1:0] variance_expected [$];

  int err_count;
  int samples_sent;
  int variances_checked;
  int window_writes;
  int burst_left;
  int gap_mode;

  sliding_window_variance_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Store one sample in the shadow ring and return the window variance in Q.8
  function automatic logic [OUT_W-1:0] advance_window_variance(input logic [IN_W-1:0] smp);
    int                w;
    int                slot;
    int                k;
    longint            s;
    longint unsigned   q;
    longint unsigned   abs_s;
    longint unsigned   num;
    longint unsigned   den;
    longint unsigned   quo;
    longint unsigned   rem;
    longint unsigned   res;
    w = (shadow_length == 0) ? 1 :
        ((int'(shadow_length) > RING_SIZE) ? RING_SIZE : int'(shadow_length));
    slot = (shadow_slot >= w) ? 0 : shadow_slot;
    shadow_ring[slot] = smp;
    slot++;
    shadow_slot = (slot >= w) ? 0 : slot;
    s = 0;
    q = 0;
    for (k = 0; k < w; k++) begin
      s += longint'(shadow_ring[k]);
      q += longint'(shadow_ring[k]) * longint'(shadow_ring[k]);
    end
    abs_s = (s < 0) ? longint'(-s) : longint'(s);
    num = longint'(w) * q - abs_s * abs_s;
    den = longint'(w) * longint'(w);
    quo = num / den;
    rem = num % den;
    res = (quo << 8) + ((rem << 8) / den);
    return res[OUT_W-1:0];
  endfunction

  // Hold off the sender between bursts; called at a falling edge
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      case (gap_mode)
        0: gap = 0;
        1: gap = $urandom_range(1, 3);
        2: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 8);
        default: gap = $urandom_range(0, 40);
      endcase
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) begin
          in_tdata = IN_W'($urandom);
          @(negedge clk);
        end
      end
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // Offer one sample word and record its variance once accepted
  task automatic send_sample(input logic [IN_W-1:0] smp, input logic typed,
                             input logic [OUT_W-1:0] typed_val);
    logic [OUT_W-1:0] predicted;
    pace_sender();
    in_tdata  = smp;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = advance_window_variance(smp);
    variance_expected.push_back(typed ? typed_val : predicted);
    samples_sent++;
    @(negedge clk);
  endtask

  // Drain the block, then write a new window length
  task automatic write_window(input logic [CFG_W-1:0] len);
    in_tvalid = 1'b0;
    while (variance_expected.size() != 0) @(negedge clk);
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_wdata = len;
    @(negedge clk);
    cfg_wen   = 1'b0;
    cfg_wdata = CFG_W'($urandom);
    shadow_length = len;
    window_writes++;
  endtask

  // Draw a sample according to the phase's value style
  function automatic logic [IN_W-1:0] draw_sample(input int style, input logic [IN_W-1:0] fixed);
    case (style)
      0: return IN_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      2: return IN_W'($signed($urandom_range(0, 64)) - 32);
      3: return fixed;
      default: return ($urandom_range(0, 1) == 1) ? fixed : IN_W'($urandom);
    endcase
  endfunction

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (variance_expected.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("ERROR: unexpected variance word %0d", out_tdata[OUT_W-1:0]);
      end else begin
        if (out_tdata[OUT_W-1:0] !== variance_expected[0]) begin
          err_count++;
          if (err_count <= 10)
            $display("ERROR: variance mismatch, expected %0d, got %0d",
                     variance_expected[0], out_tdata[OUT_W-1:0]);
        end
        void'(variance_expected.pop_front());
        variances_checked++;
      end
    end
  end

  // Stall the result side in segments of differing patterns
  initial begin
    int seg_len;
    int mode;
    int period;
    int i;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      seg_len = $urandom_range(20, 300);
      mode    = $urandom_range(0, 4);
      period  = $urandom_range(8, 90);
      for (i = 0; i < seg_len; i++) begin
        @(negedge clk);
        case (mode)
          0: out_tready = 1'b1;
          1: out_tready = ($urandom_range(0, 3) != 0);
          2: out_tready = ($urandom_range(0, 3) == 0);
          3: out_tready = ((i % period) >= (period * 3) / 4);
          default: out_tready = ((i % period) < 2);
        endcase
      end
    end
  end

  // Stimulus: reset, directed table, then random windows
  initial begin
    int r;
    int n;
    int i;
    int style;
    logic [CFG_W-1:0] len;
    logic [IN_W-1:0]  fixed;
    rst_n      = 1'b0;
    cfg_wen    = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    err_count  = 0;
    samples_sent = 0;
    variances_checked = 0;
    window_writes = 0;
    burst_left = 0;
    gap_mode   = 0;
    for (r = 0; r < RING_SIZE; r++) shadow_ring[r] = '0;
    shadow_slot   = 0;
    shadow_length = RESET_WINDOW;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table
    for (r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].kind == ROW_WINDOW)
        write_window(DIR_TABLE[r].value[CFG_W-1:0]);
      else
        send_sample(DIR_TABLE[r].value, DIR_TABLE[r].typed, DIR_TABLE[r].result);
    end

    // Random phases, mostly short windows
    while (samples_sent < DIR_ROWS + RAND_ITEMS) begin
      case ($urandom_range(0, 11))
        0: len = 8'd128;
        1: len = ($urandom_range(0, 1) == 1) ? 8'd0 : 8'd255;
        2: len = CFG_W'($urandom_range(129, 254));
        3: len = CFG_W'($urandom_range(40, 127));
        4: len = 8'd1;
        default: len = CFG_W'($urandom_range(2, 16));
      endcase
      write_window(len);
      gap_mode = $urandom_range(0, 3);
      style    = $urandom_range(0, 5);
      fixed    = IN_W'($urandom);
      n        = (len > 16 || len == 0) ? $urandom_range(4, 20) : $urandom_range(10, 50);
      for (i = 0; i < n && samples_sent < DIR_ROWS + RAND_ITEMS; i++)
        send_sample(draw_sample(style, fixed), 1'b0, '0);
    end

    // Let the last words drain, then watch for strays
    in_tvalid = 1'b0;
    while (variance_expected.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d samples across %0d window length writes; %0d variances checked.",
             samples_sent, window_writes, variances_checked);
    $display("Windows ranged over zero, one, short, full ring and saturated lengths.");
    if (err_count == 0 && variance_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("Errors: %0d", err_count);
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout with %0d variances still pending", variance_expected.size());
    $display("status: fail");
    $finish;
  end

endmodule
